// ----- rtl/core/bdq_pkg.sv -----
package bdq_pkg;

   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 16;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam func_type FUNC_PUSH_FRONT = 3'd0;
   localparam func_type FUNC_PUSH_BACK  = 3'd1;
   localparam func_type FUNC_POP_FRONT  = 3'd2;
   localparam func_type FUNC_POP_BACK   = 3'd3;
   localparam func_type FUNC_COUNT      = 3'd4;
   localparam func_type FUNC_DELETE     = 3'd5;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

endpackage

// ----- rtl/core/bdq_store.sv -----
module bdq_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bounded_deque_with_match_delete.sv -----
// push, pop and unused codes pass through the states execute, read front, read back and result
// count and delete on a non-empty list add a scan state that walks the stored entries through one memory read port
// a new transaction is taken only in idle, after the result state has loaded the result register
// the result register frees the input side while a result waits to be taken
// synchronous active-high reset empties the list; entry storage is left uninitialized
module bounded_deque_with_match_delete #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bdq_pkg::FUNC_W-1:0]   req_func,
   input  logic [bdq_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bdq_pkg::VALUE_W-1:0]  rsp_front_value,
   output logic [bdq_pkg::VALUE_W-1:0]  rsp_back_value,
   output logic [bdq_pkg::COUNT_W-1:0]  rsp_match_count,
   output logic [bdq_pkg::COUNT_W-1:0]  rsp_fill,
   output logic [bdq_pkg::STATUS_W-1:0] rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
   localparam logic [AW:0]   WRAP      = (AW + 1)'(DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_RDF  = 3'd3;
   localparam logic [2:0] S_RDB  = 3'd4;
   localparam logic [2:0] S_RES  = 3'd5;

   function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] p);
      return (p == LAST_ADDR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] p);
      return (p == '0) ? LAST_ADDR : p - 1'b1;
   endfunction

   function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] p, input logic [CW-1:0] n);
      logic [AW:0] s;
      s = (AW + 1)'(p) + (AW + 1)'(n);
      if (s >= WRAP) begin
         s = s - WRAP;
      end
      return s[AW-1:0];
   endfunction

   logic [2:0]                state_ff, state_in;
   logic [AW-1:0]             first_ff, first_in;
   logic [CW-1:0]             count_ff, count_in;
   bdq_pkg::func_type         op_ff, op_in;
   logic [WIDTH-1:0]          val_ff, val_in;
   bdq_pkg::status_type       status_ff, status_in;
   logic [CW-1:0]             match_ff, match_in;
   logic [CW-1:0]             kept_ff, kept_in;
   logic [CW-1:0]             iss_ff, iss_in;
   logic [CW-1:0]             rcv_ff, rcv_in;
   logic [AW-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]             wr_ptr_ff, wr_ptr_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [WIDTH-1:0]          front_ff, front_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bdq_pkg::VALUE_W-1:0]  rsp_front_ff, rsp_front_in;
   logic [bdq_pkg::VALUE_W-1:0]  rsp_back_ff, rsp_back_in;
   logic [bdq_pkg::COUNT_W-1:0]  rsp_match_ff, rsp_match_in;
   logic [bdq_pkg::COUNT_W-1:0]  rsp_fill_ff, rsp_fill_in;
   bdq_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [WIDTH-1:0]          wr_data;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic [WIDTH-1:0]          rd_data;

   logic [WIDTH+15:0]         req_value_ext;
   logic [WIDTH+15:0]         front_ext;
   logic [WIDTH+15:0]         back_ext;
   logic [CW+6:0]             match_ext;
   logic [CW+6:0]             fill_ext;
   logic [CW-1:0]             count_m1;

   assign req_value_ext = {{WIDTH{1'b0}}, req_value};
   assign front_ext     = {16'b0, front_ff};
   assign back_ext      = {16'b0, rd_data};
   assign match_ext     = {7'b0, match_ff};
   assign fill_ext      = {7'b0, count_ff};
   assign count_m1      = count_ff - 1'b1;

   bdq_store #(
      .DEPTH(DEPTH),
      .WIDTH(WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      match_in      = match_ff;
      kept_in       = kept_ff;
      iss_in        = iss_ff;
      rcv_in        = rcv_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_vld_in     = 1'b0;
      front_in      = front_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = first_ff;
      wr_data       = val_ff;
      rd_en         = 1'b0;
      rd_addr       = first_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_func;
               val_in   = req_value_ext[WIDTH-1:0];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = bdq_pkg::STATUS_OK;
            match_in  = '0;
            state_in  = S_RDF;
            case (op_ff)
               bdq_pkg::FUNC_PUSH_FRONT: begin
                  if (count_ff == FULL_CNT) begin
                     status_in = bdq_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = addr_dec(first_ff);
                     first_in = addr_dec(first_ff);
                     count_in = count_ff + 1'b1;
                  end
               end
               bdq_pkg::FUNC_PUSH_BACK: begin
                  if (count_ff == FULL_CNT) begin
                     status_in = bdq_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = addr_add(first_ff, count_ff);
                     count_in = count_ff + 1'b1;
                  end
               end
               bdq_pkg::FUNC_POP_FRONT: begin
                  if (count_ff == '0) begin
                     status_in = bdq_pkg::STATUS_EMPTY;
                  end else begin
                     first_in = addr_inc(first_ff);
                     count_in = count_ff - 1'b1;
                  end
               end
               bdq_pkg::FUNC_POP_BACK: begin
                  if (count_ff == '0) begin
                     status_in = bdq_pkg::STATUS_EMPTY;
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
               end
               bdq_pkg::FUNC_COUNT, bdq_pkg::FUNC_DELETE: begin
                  if (count_ff == '0) begin
                     status_in = bdq_pkg::STATUS_EMPTY;
                  end else begin
                     rd_ptr_in = first_ff;
                     wr_ptr_in = first_ff;
                     iss_in    = count_ff;
                     rcv_in    = count_ff;
                     kept_in   = '0;
                     state_in  = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            // reads run ahead, compacting writes trail behind
            if (iss_ff != '0) begin
               rd_en     = 1'b1;
               rd_addr   = rd_ptr_ff;
               rd_ptr_in = addr_inc(rd_ptr_ff);
               iss_in    = iss_ff - 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               rcv_in = rcv_ff - 1'b1;
               if (rd_data == val_ff) begin
                  match_in = match_ff + 1'b1;
               end else if (op_ff == bdq_pkg::FUNC_DELETE) begin
                  wr_en     = 1'b1;
                  wr_addr   = wr_ptr_ff;
                  wr_data   = rd_data;
                  wr_ptr_in = addr_inc(wr_ptr_ff);
                  kept_in   = kept_ff + 1'b1;
               end
               if (rcv_ff == CW'(1)) begin
                  state_in = S_RDF;
                  if (op_ff == bdq_pkg::FUNC_DELETE) begin
                     count_in = kept_in;
                  end
               end
            end
         end
         S_RDF: begin
            rd_en    = (count_ff != '0);
            rd_addr  = first_ff;
            state_in = S_RDB;
         end
         S_RDB: begin
            front_in = (count_ff != '0) ? rd_data : '0;
            rd_en    = (count_ff != '0);
            rd_addr  = addr_add(first_ff, count_m1);
            state_in = S_RES;
         end
         S_RES: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_front_in  = front_ext[15:0];
               rsp_back_in   = (count_ff != '0) ? back_ext[15:0] : '0;
               rsp_match_in  = match_ext[6:0];
               rsp_fill_in   = fill_ext[6:0];
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= '0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      match_ff      <= match_in;
      kept_ff       <= kept_in;
      iss_ff        <= iss_in;
      rcv_ff        <= rcv_in;
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      front_ff      <= front_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_match_count = rsp_match_ff;
   assign rsp_fill        = rsp_fill_ff;
   assign rsp_status      = rsp_status_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("fill above depth");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (rcv_ff >= iss_ff))
      else $error("scan received more than issued");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write of the same entry in one cycle");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RES && status_ff == bdq_pkg::STATUS_FULL) |-> (count_ff == FULL_CNT))
      else $error("full status with room left");

   a_scan_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && state_in == S_RDF) |=> !rd_vld_ff)
      else $error("read data left after scan end");

endmodule

// ----- bench/tb.sv -----
module tb;

   localparam int DQ_DEPTH = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_OPS = 1750;
   localparam int HOLD_AFTER = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 80;

   localparam bdq_pkg::func_type FUNC_UNUSED_6 = 3'd6;
   localparam bdq_pkg::func_type FUNC_UNUSED_7 = 3'd7;

   localparam int PHASE_FILL  = 0;
   localparam int PHASE_DRAIN = 1;
   localparam int PHASE_MIXED = 2;
   localparam int PHASE_NOISE = 3;

   typedef struct packed {
      bdq_pkg::func_type              func;
      logic [bdq_pkg::VALUE_W-1:0]    value;
   } deque_op_type;

   typedef struct packed {
      logic [bdq_pkg::VALUE_W-1:0]    front_value;
      logic [bdq_pkg::VALUE_W-1:0]    back_value;
      logic [bdq_pkg::COUNT_W-1:0]    match_count;
      logic [bdq_pkg::COUNT_W-1:0]    fill;
      bdq_pkg::status_type            status;
   } deque_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bdq_pkg::func_type req_func = bdq_pkg::FUNC_PUSH_FRONT;
   logic [bdq_pkg::VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [bdq_pkg::VALUE_W-1:0] rsp_front_value;
   logic [bdq_pkg::VALUE_W-1:0] rsp_back_value;
   logic [bdq_pkg::COUNT_W-1:0] rsp_match_count;
   logic [bdq_pkg::COUNT_W-1:0] rsp_fill;
   bdq_pkg::status_type rsp_status;

   bounded_deque_with_match_delete i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_match_count (rsp_match_count),
      .rsp_fill        (rsp_fill),
      .rsp_status      (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // deque shadow state
   logic [bdq_pkg::VALUE_W-1:0] dq_store [DQ_DEPTH];
   logic [5:0] dq_head = '0;
   int dq_fill = 0;

   deque_op_type pending_ops [$];
   deque_rsp_type predicted_rsp [$];
   logic [bdq_pkg::VALUE_W-1:0] value_pool [4];

   int errors = 0;
   int results_seen = 0;
   int cycle_count = 0;
   int random_ops = 0;
   int n_full_seen = 0;
   int n_empty_seen = 0;
   int n_removed = 0;
   int peak_fill = 0;
   logic req_fire = 1'b0;
   int tx_gap = 0;
   logic tx_burst = 1'b0;
   int rx_stall = 0;
   int rx_hold = 0;
   logic rx_hold_done = 1'b0;
   logic rx_burst = 1'b0;

   function automatic logic [5:0] dq_slot(input int offset);
      return dq_head + offset[5:0];
   endfunction

   task automatic deque_apply(input deque_op_type op, output deque_rsp_type rsp);
      int hits;
      int kept;
      logic [bdq_pkg::VALUE_W-1:0] e;
      bdq_pkg::status_type st;
      hits = 0;
      st = bdq_pkg::STATUS_OK;
      case (op.func)
         bdq_pkg::FUNC_PUSH_FRONT, bdq_pkg::FUNC_PUSH_BACK: begin
            if (dq_fill >= DQ_DEPTH) begin
               st = bdq_pkg::STATUS_FULL;
            end else if (op.func == bdq_pkg::FUNC_PUSH_FRONT) begin
               dq_head = dq_head - 6'd1;
               dq_store[dq_head] = op.value;
               dq_fill++;
            end else begin
               dq_store[dq_slot(dq_fill)] = op.value;
               dq_fill++;
            end
         end
         bdq_pkg::FUNC_POP_FRONT, bdq_pkg::FUNC_POP_BACK: begin
            if (dq_fill == 0) begin
               st = bdq_pkg::STATUS_EMPTY;
            end else begin
               if (op.func == bdq_pkg::FUNC_POP_FRONT) dq_head = dq_head + 6'd1;
               dq_fill--;
            end
         end
         bdq_pkg::FUNC_COUNT: begin
            if (dq_fill == 0) begin
               st = bdq_pkg::STATUS_EMPTY;
            end else begin
               for (int i = 0; i < dq_fill; i++)
                  if (dq_store[dq_slot(i)] == op.value) hits++;
            end
         end
         bdq_pkg::FUNC_DELETE: begin
            if (dq_fill == 0) begin
               st = bdq_pkg::STATUS_EMPTY;
            end else begin
               kept = 0;
               for (int i = 0; i < dq_fill; i++) begin
                  e = dq_store[dq_slot(i)];
                  if (e == op.value) begin
                     hits++;
                  end else begin
                     dq_store[dq_slot(kept)] = e;
                     kept++;
                  end
               end
               dq_fill = kept;
            end
         end
         default: ;
      endcase
      if (dq_fill == 0) begin
         rsp.front_value = '0;
         rsp.back_value = '0;
      end else begin
         rsp.front_value = dq_store[dq_slot(0)];
         rsp.back_value = dq_store[dq_slot(dq_fill - 1)];
      end
      rsp.match_count = hits[bdq_pkg::COUNT_W-1:0];
      rsp.fill = dq_fill[bdq_pkg::COUNT_W-1:0];
      rsp.status = st;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [bdq_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 99) < 75) return value_pool[2'($urandom_range(0, 3))];
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic bdq_pkg::func_type pick_func(input int kind);
      int r;
      int push_w;
      int pop_w;
      int count_w;
      r = $urandom_range(0, 99);
      case (kind)
         PHASE_FILL: begin
            push_w = 80; pop_w = 8; count_w = 8;
         end
         PHASE_DRAIN: begin
            push_w = 15; pop_w = 70; count_w = 10;
         end
         default: begin
            push_w = 45; pop_w = 35; count_w = 12;
         end
      endcase
      if (r < push_w)
         return $urandom_range(0, 1) ? bdq_pkg::FUNC_PUSH_BACK : bdq_pkg::FUNC_PUSH_FRONT;
      if (r < push_w + pop_w)
         return $urandom_range(0, 1) ? bdq_pkg::FUNC_POP_BACK : bdq_pkg::FUNC_POP_FRONT;
      if (r < push_w + pop_w + count_w) return bdq_pkg::FUNC_COUNT;
      return bdq_pkg::FUNC_DELETE;
   endfunction

   task automatic add_op(input bdq_pkg::func_type f, input logic [bdq_pkg::VALUE_W-1:0] v);
      deque_op_type op;
      op.func = f;
      op.value = v;
      pending_ops.push_back(op);
      if (f != FUNC_UNUSED_6 && f != FUNC_UNUSED_7) random_ops++;
   endtask

   task automatic refresh_pool();
      for (int i = 0; i < 4; i++) value_pool[i[1:0]] = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) value_pool[0] = '0;
      if ($urandom_range(0, 3) == 0) value_pool[1] = '1;
   endtask

   // sender
   always @(negedge clock) begin : driver
      deque_op_type op;
      logic nv;
      nv = req_valid;
      if (reset) begin
         nv = 1'b0;
      end else if (!req_valid || req_fire) begin
         if (tx_gap > 0) begin
            tx_gap--;
            nv = 1'b0;
         end else if (pending_ops.size() != 0) begin
            op = pending_ops.pop_front();
            req_func <= op.func;
            req_value <= op.value;
            nv = 1'b1;
            tx_gap = tx_burst ? 0 : pick_gap();
         end else begin
            nv = 1'b0;
         end
      end
      if ($urandom_range(0, 299) == 0) tx_burst = !tx_burst;
      req_valid <= nv;
   end

   // receiver, with one long hold-off to back up the input side
   always @(negedge clock) begin : receiver
      logic nr;
      if (!rx_hold_done && results_seen >= HOLD_AFTER) begin
         rx_hold = HOLD_CYCLES;
         rx_hold_done = 1'b1;
      end
      if (rx_hold > 0) begin
         rx_hold--;
         nr = 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall--;
         nr = 1'b0;
      end else begin
         nr = 1'b1;
         rx_stall = rx_burst ? 0 : pick_gap();
      end
      if ($urandom_range(0, 299) == 0) rx_burst = !rx_burst;
      rsp_ready <= nr;
   end

   // monitor and scoreboard
   always @(posedge clock) begin : monitor
      deque_rsp_type want;
      deque_op_type op;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (predicted_rsp.size() == 0) begin
               $error("result transaction with none outstanding");
               errors++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("front_value", 32'(want.front_value), 32'(rsp_front_value));
               check_field("back_value", 32'(want.back_value), 32'(rsp_back_value));
               check_field("match_count", 32'(want.match_count), 32'(rsp_match_count));
               check_field("fill", 32'(want.fill), 32'(rsp_fill));
               check_field("status", 32'(want.status), 32'(rsp_status));
            end
         end
         if (req_valid && req_ready) begin
            op.func = req_func;
            op.value = req_value;
            deque_apply(op, want);
            predicted_rsp.push_back(want);
            if (want.status == bdq_pkg::STATUS_FULL) n_full_seen++;
            if (want.status == bdq_pkg::STATUS_EMPTY) n_empty_seen++;
            if (op.func == bdq_pkg::FUNC_DELETE) n_removed += int'(want.match_count);
            if (dq_fill > peak_fill) peak_fill = dq_fill;
         end
         req_fire <= req_valid && req_ready;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bounded_deque_with_match_delete: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      logic [bdq_pkg::VALUE_W-1:0] v;
      int kind;
      int len;

      // directed: empty list cases, unused codes, extreme values
      add_op(bdq_pkg::FUNC_POP_FRONT, 16'h1234);
      add_op(bdq_pkg::FUNC_POP_BACK, 16'h0000);
      add_op(bdq_pkg::FUNC_COUNT, 16'h0000);
      add_op(bdq_pkg::FUNC_DELETE, 16'hFFFF);
      add_op(FUNC_UNUSED_6, 16'hFFFF);
      add_op(FUNC_UNUSED_7, 16'h0000);
      add_op(bdq_pkg::FUNC_PUSH_BACK, 16'hFFFF);
      add_op(bdq_pkg::FUNC_PUSH_FRONT, 16'h0000);
      add_op(bdq_pkg::FUNC_PUSH_BACK, 16'hFFFF);
      add_op(bdq_pkg::FUNC_PUSH_FRONT, 16'h8000);
      add_op(bdq_pkg::FUNC_COUNT, 16'hFFFF);
      add_op(bdq_pkg::FUNC_COUNT, 16'h1234);
      add_op(FUNC_UNUSED_6, 16'h5555);
      add_op(bdq_pkg::FUNC_DELETE, 16'hFFFF);
      add_op(bdq_pkg::FUNC_POP_BACK, 16'hAAAA);
      add_op(bdq_pkg::FUNC_POP_FRONT, 16'h5555);
      add_op(bdq_pkg::FUNC_PUSH_FRONT, 16'h0005);
      add_op(bdq_pkg::FUNC_DELETE, 16'h0005);
      add_op(bdq_pkg::FUNC_PUSH_BACK, 16'h0007);
      add_op(bdq_pkg::FUNC_PUSH_BACK, 16'h0007);
      add_op(bdq_pkg::FUNC_PUSH_FRONT, 16'h0009);
      add_op(bdq_pkg::FUNC_DELETE, 16'h0009);
      add_op(bdq_pkg::FUNC_DELETE, 16'h0003);
      add_op(bdq_pkg::FUNC_POP_FRONT, 16'h0000);
      add_op(bdq_pkg::FUNC_POP_BACK, 16'h0000);

      // fill with one value, push into a full list, then count and delete all
      random_ops = 0;
      v = 16'($urandom_range(0, 65535));
      for (int i = 0; i < DQ_DEPTH; i++)
         add_op($urandom_range(0, 1) ? bdq_pkg::FUNC_PUSH_BACK : bdq_pkg::FUNC_PUSH_FRONT, v);
      add_op(bdq_pkg::FUNC_PUSH_FRONT, 16'($urandom_range(0, 65535)));
      add_op(bdq_pkg::FUNC_PUSH_BACK, 16'($urandom_range(0, 65535)));
      add_op(bdq_pkg::FUNC_COUNT, v);
      add_op(bdq_pkg::FUNC_DELETE, v);

      while (random_ops < RANDOM_OPS) begin
         refresh_pool();
         kind = $urandom_range(0, 9);
         if (kind < 4) kind = PHASE_FILL;
         else if (kind < 6) kind = PHASE_DRAIN;
         else if (kind < 9) kind = PHASE_MIXED;
         else kind = PHASE_NOISE;
         len = (kind == PHASE_NOISE) ? $urandom_range(3, 10) : $urandom_range(20, 120);
         for (int i = 0; i < len; i++) begin
            if (kind == PHASE_NOISE && $urandom_range(0, 1))
               add_op($urandom_range(0, 1) ? FUNC_UNUSED_7 : FUNC_UNUSED_6,
                      16'($urandom_range(0, 65535)));
            else
               add_op(pick_func(kind == PHASE_NOISE ? PHASE_MIXED : kind), pick_value());
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d results: %0d full pushes dropped, %0d empty-list ops",
               results_seen, n_full_seen, n_empty_seen);
      $display("peak fill %0d, %0d entries removed by delete", peak_fill, n_removed);
      if (errors == 0) begin
         $display("bounded_deque_with_match_delete: match");
      end else begin
         $display("bounded_deque_with_match_delete: mismatch");
      end
      $finish;
   end

endmodule
